[rtl/core/hpw_pkg.sv]
package hpw_pkg;

  // Window geometry.
  localparam int WINDOW_MAX = 32;
  localparam int PART_GROUP = 4;
  localparam int NUM_PART   = WINDOW_MAX / PART_GROUP;
  localparam int NUM_HALF   = 2;
  localparam int HALF_GROUP = NUM_PART / NUM_HALF;

  // Field and datapath widths.
  localparam int RES_W      = 8;
  localparam int WIN_LEN_W  = 6;
  localparam int THR_W      = 8;
  localparam int FILL_W     = 6;
  localparam int POS_W      = 16;
  localparam int PROP_W     = 8;
  localparam int PART_W     = 10;
  localparam int HALF_W     = 12;
  localparam int SUM_W      = 13;
  localparam int LIMIT_W    = 14;
  localparam int EXC_W      = 13;
  localparam int BOOST_W    = 10;
  localparam int ENERGY_W   = 14;
  localparam int DIVD_W     = 15;
  localparam int QUO_W      = 15;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HELIX_THRESHOLD = 2'd1;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 6'd6;
  localparam logic [THR_W-1:0]     THR_RESET     = 8'd103;

  // Positions stop at this value.
  localparam logic [POS_W-1:0] POS_LIMIT = 16'hFFFF;

  localparam logic [BOOST_W-1:0] BOOST_BASE  = 10'd100;
  localparam logic [BOOST_W-1:0] BOOST_CAP   = 10'd1000;
  localparam logic [QUO_W-1:0]   BOOST_Q_CAP = 15'd900;

  // Character codes.
  localparam logic [RES_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [RES_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [RES_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [RES_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [RES_W-1:0] CASE_OFFSET  = 8'd32;

  localparam logic [PROP_W-1:0] PROP_UNKNOWN = 8'd90;

  // Helix propensity in hundredths, letters A to Z.
  localparam logic [PROP_W-1:0] LETTER_PROP [26] = '{
    8'd145, 8'd90,  8'd77,  8'd98,  8'd153, 8'd116, 8'd53,  8'd124, 8'd100,
    8'd90,  8'd123, 8'd134, 8'd130, 8'd73,  8'd90,  8'd57,  8'd117, 8'd97,
    8'd79,  8'd77,  8'd90,  8'd97,  8'd108, 8'd90,  8'd69,  8'd90
  };

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic                 qual;
    logic                 last;
    logic [WIN_LEN_W-1:0] w;
    logic [POS_W-1:0]     wstart;
    logic [POS_W-1:0]     pos;
    logic [EXC_W-1:0]     excess;
  } hpw_work_t;

  // Request to the boost divider.
  typedef struct packed {
    logic                 start;
    logic [DIVD_W-1:0]    dividend;
    logic [WIN_LEN_W-1:0] divisor;
  } hpw_div_req_t;

  function automatic logic [PROP_W-1:0] hpw_prop(input logic [RES_W-1:0] c);
    logic [RES_W-1:0] u;
    logic [4:0]       idx;
    u = ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ? c - CASE_OFFSET : c;
    idx = 5'(u - CHAR_UPPER_A);
    if ((u >= CHAR_UPPER_A) && (u <= CHAR_UPPER_Z)) begin
      return LETTER_PROP[idx];
    end
    return PROP_UNKNOWN;
  endfunction

endpackage

[rtl/core/hpw_if.sv]
interface hpw_in_if;
  import hpw_pkg::*;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] residue;
  logic             last_residue;

  modport source (output valid, output residue, output last_residue, input ready);
  modport sink (input valid, input residue, input last_residue, output ready);
endinterface

interface hpw_out_if;
  import hpw_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       seed_valid;
  logic [POS_W-1:0]           seed_start;
  logic [POS_W-1:0]           seed_end;
  logic [BOOST_W-1:0]         boost_hundredths;
  logic signed [ENERGY_W-1:0] energy_half_hundredths;
  logic                       sequence_done;

  modport source (output valid, output seed_valid, output seed_start, output seed_end,
                  output boost_hundredths, output energy_half_hundredths,
                  output sequence_done, input ready);
  modport sink (input valid, input seed_valid, input seed_start, input seed_end,
                input boost_hundredths, input energy_half_hundredths,
                input sequence_done, output ready);
endinterface

interface hpw_cfg_if;
  import hpw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/hpw_front.sv]
module hpw_front (
  input  logic              clk,
  input  logic              rst_n,
  hpw_in_if.sink            in_chan,
  hpw_cfg_if.sink           cfg_chan,
  output logic              push_valid,
  input  logic              push_ready,
  output hpw_pkg::hpw_work_t push_data
);
  import hpw_pkg::*;

  logic [WIN_LEN_W-1:0] wlen_r;
  logic [THR_W-1:0]     thr_r;
  logic [PROP_W-1:0]    win_r   [WINDOW_MAX];
  logic [PROP_W-1:0]    win_nxt [WINDOW_MAX];
  logic [FILL_W-1:0]    fill_r;
  logic [FILL_W-1:0]    fill_inc;
  logic [POS_W-1:0]     pos_r;
  logic [WIN_LEN_W-1:0] weff;
  logic                 adv;
  logic                 fire;
  logic [PART_W-1:0]    part [NUM_PART];

  // Stage one: partial sums of four masked window entries.
  logic                 s1_valid_r;
  logic [PART_W-1:0]    s1_part_r [NUM_PART];
  logic                 s1_full_r;
  logic [LIMIT_W-1:0]   s1_limit_r;
  logic [WIN_LEN_W-1:0] s1_w_r;
  logic [POS_W-1:0]     s1_pos_r;
  logic                 s1_last_r;

  // Stage two: two half sums.
  logic                 s2_valid_r;
  logic [HALF_W-1:0]    s2_half_r [NUM_HALF];
  logic [HALF_W-1:0]    half [NUM_HALF];
  logic                 s2_full_r;
  logic [LIMIT_W-1:0]   s2_limit_r;
  logic [WIN_LEN_W-1:0] s2_w_r;
  logic [POS_W-1:0]     s2_pos_r;
  logic                 s2_last_r;

  // Stage three: the classified work unit.
  logic                 s3_valid_r;
  hpw_work_t            s3_work_r;
  hpw_work_t            work;
  logic [SUM_W-1:0]     sum;

  assign cfg_chan.ready = 1'b1;

  // The whole front advances together; it halts only when a unit waits for queue space.
  assign adv           = !s3_valid_r || push_ready;
  assign in_chan.ready = adv;
  assign fire          = in_chan.valid && adv;
  assign push_valid    = s3_valid_r;
  assign push_data     = s3_work_r;

  always_comb begin
    if (wlen_r == '0) begin
      weff = WIN_LEN_W'(1);
    end else if (wlen_r > WIN_LEN_W'(WINDOW_MAX)) begin
      weff = WIN_LEN_W'(WINDOW_MAX);
    end else begin
      weff = wlen_r;
    end
  end

  assign fill_inc = (fill_r < FILL_W'(WINDOW_MAX)) ? fill_r + FILL_W'(1) : fill_r;

  always_comb begin
    win_nxt[0] = hpw_prop(in_chan.residue);
    for (int i = 1; i < WINDOW_MAX; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_PART; g++) begin
      part[g] = '0;
      for (int k = 0; k < PART_GROUP; k++) begin
        if (WIN_LEN_W'(g * PART_GROUP + k) < weff) begin
          part[g] = part[g] + PART_W'(win_nxt[g * PART_GROUP + k]);
        end
      end
    end
  end

  always_comb begin
    for (int h = 0; h < NUM_HALF; h++) begin
      half[h] = '0;
      for (int k = 0; k < HALF_GROUP; k++) begin
        half[h] = half[h] + HALF_W'(s1_part_r[h * HALF_GROUP + k]);
      end
    end
  end

  always_comb begin
    sum         = SUM_W'(s2_half_r[0]) + SUM_W'(s2_half_r[1]);
    work.qual   = s2_full_r && (LIMIT_W'(sum) > s2_limit_r);
    work.last   = s2_last_r;
    work.w      = s2_w_r;
    work.pos    = s2_pos_r;
    work.wstart = s2_pos_r - (POS_W'(s2_w_r) - POS_W'(1));
    work.excess = EXC_W'(sum - s2_limit_r[SUM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r     <= WIN_LEN_RESET;
      thr_r      <= THR_RESET;
      fill_r     <= '0;
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          REG_WINDOW_LENGTH:   wlen_r <= cfg_chan.data[WIN_LEN_W-1:0];
          REG_HELIX_THRESHOLD: thr_r  <= cfg_chan.data[THR_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        if (in_chan.last_residue) begin
          fill_r <= '0;
          pos_r  <= '0;
        end else begin
          fill_r <= fill_inc;
          pos_r  <= (pos_r < POS_LIMIT) ? pos_r + POS_W'(1) : pos_r;
        end
      end
      if (adv) begin
        s1_valid_r <= fire;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r && (work.qual || work.last);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      win_r <= win_nxt;
    end
    if (adv) begin
      s1_part_r  <= part;
      s1_full_r  <= (fill_inc >= weff);
      s1_limit_r <= LIMIT_W'(thr_r * weff);
      s1_w_r     <= weff;
      s1_pos_r   <= pos_r;
      s1_last_r  <= in_chan.last_residue;
      s2_half_r  <= half;
      s2_full_r  <= s1_full_r;
      s2_limit_r <= s1_limit_r;
      s2_w_r     <= s1_w_r;
      s2_pos_r   <= s1_pos_r;
      s2_last_r  <= s1_last_r;
      s3_work_r  <= work;
    end
  end

endmodule

[rtl/core/hpw_queue.sv]
module hpw_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  hpw_pkg::hpw_work_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output hpw_pkg::hpw_work_t pop_data
);
  import hpw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  hpw_work_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W_Q-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r < CNT_W_Q'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W_Q'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W_Q'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/hpw_div.sv]
module hpw_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hpw_pkg::hpw_div_req_t req,
  output logic                  busy,
  output logic [hpw_pkg::QUO_W-1:0] quotient
);
  import hpw_pkg::*;

  // Restoring division, one quotient bit per cycle.
  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [WIN_LEN_W-1:0] rem_r;
  logic [WIN_LEN_W-1:0] dvs_r;
  logic [DIVD_W-1:0]    dvd_r;
  logic [QUO_W-1:0]     quo_r;
  logic [WIN_LEN_W:0]   rem_sh;
  logic                 take;

  assign busy     = busy_r;
  assign quotient = quo_r;
  assign rem_sh   = {rem_r, dvd_r[DIVD_W-1]};
  assign take     = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIVD_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      dvd_r <= req.dividend;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? WIN_LEN_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[WIN_LEN_W-1:0];
      dvd_r <= {dvd_r[DIVD_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], take};
    end
  end

endmodule

[rtl/core/hpw_back.sv]
module hpw_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  hpw_pkg::hpw_work_t    pop_data,
  output hpw_pkg::hpw_div_req_t div_req,
  input  logic                  div_busy,
  input  logic [hpw_pkg::QUO_W-1:0] div_quo,
  hpw_out_if.source             out_chan
);
  import hpw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } hpw_back_st_t;

  hpw_back_st_t st_r, st_nxt;

  // Open seed.
  logic             open_r,  open_nxt;
  logic [POS_W-1:0] ostart_r, ostart_nxt;
  logic [POS_W-1:0] oend_r,  oend_nxt;
  logic [EXC_W-1:0] best_r,  best_nxt;
  logic [EXC_W-1:0] first_r, first_nxt;

  // A final seed still owed after a closing one.
  logic                 pend_last_r, pend_last_nxt;
  logic [WIN_LEN_W-1:0] pend_w_r,    pend_w_nxt;

  // Result under construction.
  logic             job_valid_r, job_valid_nxt;
  logic [POS_W-1:0] job_start_r, job_start_nxt;
  logic [POS_W-1:0] job_end_r,   job_end_nxt;
  logic [EXC_W-1:0] job_first_r, job_first_nxt;
  logic             job_done_r,  job_done_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_seed_r;
  logic [POS_W-1:0]           out_start_r;
  logic [POS_W-1:0]           out_end_r;
  logic [BOOST_W-1:0]         out_boost_r;
  logic signed [ENERGY_W-1:0] out_energy_r;
  logic                       out_done_r;
  logic                       out_load;

  // Seed state after the popped unit's window is applied.
  logic             merge;
  logic             close;
  logic             upd_open;
  logic [POS_W-1:0] upd_start;
  logic [POS_W-1:0] upd_end;
  logic [EXC_W-1:0] upd_best;
  logic [EXC_W-1:0] upd_first;
  logic [BOOST_W-1:0] boost;

  function automatic logic [DIVD_W-1:0] times_five(input logic [EXC_W-1:0] x);
    return {x, 2'b00} + DIVD_W'(x);
  endfunction

  assign out_chan.valid                  = out_valid_r;
  assign out_chan.seed_valid             = out_seed_r;
  assign out_chan.seed_start             = out_start_r;
  assign out_chan.seed_end               = out_end_r;
  assign out_chan.boost_hundredths       = out_boost_r;
  assign out_chan.energy_half_hundredths = out_energy_r;
  assign out_chan.sequence_done          = out_done_r;

  assign pop_ready = (st_r == ST_IDLE);

  always_comb begin
    merge = pop_data.qual && open_r &&
            ({1'b0, pop_data.wstart} <= ({1'b0, oend_r} + (POS_W + 1)'(1)));
    close = pop_data.qual && open_r && !merge;
    if (!pop_data.qual) begin
      upd_open  = open_r;
      upd_start = ostart_r;
      upd_end   = oend_r;
      upd_best  = best_r;
      upd_first = first_r;
    end else if (merge) begin
      upd_open  = 1'b1;
      upd_start = ostart_r;
      upd_end   = pop_data.pos;
      upd_best  = (pop_data.excess > best_r) ? pop_data.excess : best_r;
      upd_first = first_r;
    end else begin
      upd_open  = 1'b1;
      upd_start = pop_data.wstart;
      upd_end   = pop_data.pos;
      upd_best  = pop_data.excess;
      upd_first = pop_data.excess;
    end
  end

  always_comb begin
    if (!job_valid_r) begin
      boost = '0;
    end else if (div_quo >= BOOST_Q_CAP) begin
      boost = BOOST_CAP;
    end else begin
      boost = BOOST_W'(div_quo) + BOOST_BASE;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    open_nxt      = open_r;
    ostart_nxt    = ostart_r;
    oend_nxt      = oend_r;
    best_nxt      = best_r;
    first_nxt     = first_r;
    pend_last_nxt = pend_last_r;
    pend_w_nxt    = pend_w_r;
    job_valid_nxt = job_valid_r;
    job_start_nxt = job_start_r;
    job_end_nxt   = job_end_r;
    job_first_nxt = job_first_r;
    job_done_nxt  = job_done_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    div_req       = '0;

    unique case (st_r)
      ST_IDLE: begin
        if (pop_valid) begin
          if (close) begin
            // The old seed goes out first; the new one opens behind it.
            job_valid_nxt    = 1'b1;
            job_start_nxt    = ostart_r;
            job_end_nxt      = oend_r;
            job_first_nxt    = first_r;
            job_done_nxt     = 1'b0;
            div_req.start    = 1'b1;
            div_req.dividend = times_five(best_r);
            div_req.divisor  = pop_data.w;
            pend_last_nxt    = pop_data.last;
            pend_w_nxt       = pop_data.w;
            open_nxt         = upd_open;
            ostart_nxt       = upd_start;
            oend_nxt         = upd_end;
            best_nxt         = upd_best;
            first_nxt        = upd_first;
            st_nxt           = ST_DIV;
          end else if (pop_data.last) begin
            job_valid_nxt    = upd_open;
            job_start_nxt    = upd_start;
            job_end_nxt      = upd_end;
            job_first_nxt    = upd_first;
            job_done_nxt     = 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = times_five(upd_best);
            div_req.divisor  = pop_data.w;
            open_nxt         = 1'b0;
            ostart_nxt       = '0;
            oend_nxt         = '0;
            best_nxt         = '0;
            first_nxt        = '0;
            st_nxt           = ST_DIV;
          end else begin
            open_nxt   = upd_open;
            ostart_nxt = upd_start;
            oend_nxt   = upd_end;
            best_nxt   = upd_best;
            first_nxt  = upd_first;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          if (pend_last_r) begin
            job_valid_nxt    = open_r;
            job_start_nxt    = ostart_r;
            job_end_nxt      = oend_r;
            job_first_nxt    = first_r;
            job_done_nxt     = 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = times_five(best_r);
            div_req.divisor  = pend_w_r;
            pend_last_nxt    = 1'b0;
            open_nxt         = 1'b0;
            ostart_nxt       = '0;
            oend_nxt         = '0;
            best_nxt         = '0;
            first_nxt        = '0;
            st_nxt           = ST_DIV;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      open_r      <= 1'b0;
      ostart_r    <= '0;
      oend_r      <= '0;
      best_r      <= '0;
      first_r     <= '0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      open_r      <= open_nxt;
      ostart_r    <= ostart_nxt;
      oend_r      <= oend_nxt;
      best_r      <= best_nxt;
      first_r     <= first_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_w_r    <= pend_w_nxt;
    job_valid_r <= job_valid_nxt;
    job_start_r <= job_start_nxt;
    job_end_r   <= job_end_nxt;
    job_first_r <= job_first_nxt;
    job_done_r  <= job_done_nxt;
    if (out_load) begin
      out_seed_r   <= job_valid_r;
      out_start_r  <= job_valid_r ? job_start_r : '0;
      out_end_r    <= job_valid_r ? job_end_r : '0;
      out_boost_r  <= boost;
      out_energy_r <= job_valid_r ? $signed(ENERGY_W'(0) - {1'b0, job_first_r}) : '0;
      out_done_r   <= job_done_r;
    end
  end

endmodule

[rtl/core/helix_propensity_window_scan_unit.sv]
// Channel    Dir  Payload                                        Accepted when
// in_chan    in   residue, last_residue                          valid && ready
// out_chan   out  seed_valid, seed_start, seed_end,              valid && ready
//                 boost_hundredths, energy_half_hundredths,
//                 sequence_done
// cfg_chan   in   index, data                                    valid && ready
//
// Residues are taken one per cycle unless the input stalls; each goes through the stage
// one, two and three registers, and queued work then through the work queue to the seed
// logic. The back end pops no new work while a result waits on the 15-step boost divider
// and the output register handover. The input stalls only while the work queue is full;
// results wait in the output register. Reset is synchronous and active low: it empties the
// pipeline, queue and open seed and restores a window length of 6 and a threshold of 103.
module helix_propensity_window_scan_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  hpw_in_if.sink     in_chan,
  hpw_out_if.source  out_chan,
  hpw_cfg_if.sink    cfg_chan
);
  import hpw_pkg::*;

  // The front maps each residue to its propensity, keeps the window and sums it through a
  // short registered adder tree, then checks the sum against threshold times window. Only
  // requests that matter to the back end, namely qualifying windows and sequence ends, are
  // queued; other residues leave no trace beyond the window itself.
  logic         push_valid;
  logic         push_ready;
  hpw_work_t    push_data;
  logic         pop_valid;
  logic         pop_ready;
  hpw_work_t    pop_data;
  hpw_div_req_t div_req;
  logic         div_busy;
  logic [QUO_W-1:0] div_quo;

  hpw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue lets the front keep streaming while the back end divides.
  hpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end merges windows into seeds. A window that cannot merge closes the open seed,
  // which is reported before the new seed's sequence end, if any. Every window length in
  // use travels with its request, so configuration changes never reach work in flight.
  hpw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .div_req   (div_req),
    .div_busy  (div_busy),
    .div_quo   (div_quo),
    .out_chan  (out_chan)
  );

  // The boost is 100 plus five times the best excess divided by the window length, capped at 1000.
  hpw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quo)
  );

endmodule

[verif/tb_helix_propensity_window_scan_unit.sv]
module tb_helix_propensity_window_scan_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hpw_pkg::*;

  // Test bench timing and pacing.
  localparam int STALL_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int IDLE_PERCENT   = 12;
  localparam int MISMATCH_SHOWN = 10;

  // The two unused register indexes; writes to them must leave the block unchanged.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Scoring constants, stated independently of the design package.
  localparam int unsigned POSITION_CEILING = 65535;
  localparam int unsigned BOOST_FLOOR      = 100;
  localparam int unsigned BOOST_CEILING    = 1000;
  localparam int unsigned BOOST_SLOPE      = 5;
  localparam int unsigned SCORE_UNKNOWN    = 90;
  localparam logic [RES_W-1:0] LOWER_CASE_BIT = 8'h20;

  typedef struct packed {
    logic                 seed_valid;
    logic [POS_W-1:0]     seed_start;
    logic [POS_W-1:0]     seed_end;
    logic [BOOST_W-1:0]   boost;
    logic [ENERGY_W-1:0]  energy;
    logic                 done;
  } scan_result_t;

  typedef struct {
    logic [RES_W-1:0] residue;
    logic             fin;
    bit               typed;
    scan_result_t     want;
  } stim_row_t;

  // The end marker of a sequence in which no seed was found.
  localparam scan_result_t END_ONLY = '{1'b0, 16'd0, 16'd0, 10'd0, 14'd0, 1'b1};

  logic clk = 1'b0;
  logic rst_n;
  bit   steady_flow;

  hpw_in_if  in_if ();
  hpw_out_if out_if ();
  hpw_cfg_if cfg_if ();

  helix_propensity_window_scan_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #4 clk = ~clk;

  // Shadow copy of the scanner: the window of recent propensities (newest first), the
  // running position, how far the window has filled since the sequence began, and the
  // seed currently being grown.
  logic [PROP_W-1:0]    recent_props [WINDOW_MAX];
  int unsigned          scan_pos;
  int unsigned          fill_depth;
  bit                   seed_live;
  int unsigned          seed_first;
  int unsigned          seed_last;
  int unsigned          peak_excess;
  int unsigned          opening_excess;
  logic [WIN_LEN_W-1:0] span_reg;
  logic [THR_W-1:0]     thr_reg;

  scan_result_t awaited_results [$];
  scan_result_t step_results [$];
  stim_row_t    directed_rows [$];

  int mismatch_count;
  int seed_count;
  int done_count;
  int residues_sent;
  int sequences_sent;
  int settings_used;

  // Helix propensity of a character code in hundredths.  Setting bit 5 folds upper case
  // onto lower case; no code outside the two letter ranges lands on a lower case letter.
  function automatic int unsigned helix_score(input logic [RES_W-1:0] code);
    logic [RES_W-1:0] folded;
    folded = code | LOWER_CASE_BIT;
    case (folded)
      "a":      return 145;
      "c", "t": return 77;
      "d":      return 98;
      "e":      return 153;
      "f":      return 116;
      "g":      return 53;
      "h":      return 124;
      "i":      return 100;
      "k":      return 123;
      "l":      return 134;
      "m":      return 130;
      "n":      return 73;
      "p":      return 57;
      "q":      return 117;
      "r", "v": return 97;
      "s":      return 79;
      "w":      return 108;
      "y":      return 69;
      default:  return SCORE_UNKNOWN;
    endcase
  endfunction

  // Everything except the registers goes back to its reset value at the end of a sequence.
  function automatic void restart_scan();
    foreach (recent_props[i]) recent_props[i] = '0;
    scan_pos       = 0;
    fill_depth     = 0;
    seed_live      = 1'b0;
    seed_first     = 0;
    seed_last      = 0;
    peak_excess    = 0;
    opening_excess = 0;
  endfunction

  // The boost uses the best window of the seed; the energy uses the window that opened it.
  function automatic scan_result_t seed_record(input int unsigned span, input logic done);
    scan_result_t r;
    int unsigned  boost;
    boost = BOOST_FLOOR + (BOOST_SLOPE * peak_excess) / span;
    if (boost > BOOST_CEILING) begin
      boost = BOOST_CEILING;
    end
    r.seed_valid = 1'b1;
    r.seed_start = POS_W'(seed_first);
    r.seed_end   = POS_W'(seed_last);
    r.boost      = BOOST_W'(boost);
    r.energy     = ENERGY_W'(0 - opening_excess);
    r.done       = done;
    return r;
  endfunction

  // Advances the shadow scanner by one residue and leaves the results that it causes in
  // step_results: at most a closed seed followed by the end-of-sequence result.
  function automatic void advance_scan(input logic [RES_W-1:0] residue, input logic fin);
    int unsigned span;
    int unsigned total;
    int unsigned limit;
    int unsigned wstart;
    int unsigned excess;
    span = span_reg;
    if (span == 0) begin
      span = 1;
    end
    if (span > WINDOW_MAX) begin
      span = WINDOW_MAX;
    end
    for (int i = WINDOW_MAX - 1; i > 0; i--) begin
      recent_props[i] = recent_props[i-1];
    end
    recent_props[0] = PROP_W'(helix_score(residue));
    if (fill_depth < WINDOW_MAX) begin
      fill_depth++;
    end
    total = 0;
    for (int i = 0; i < span; i++) begin
      total += recent_props[i];
    end
    limit = thr_reg * span;
    if (fill_depth >= span && total > limit) begin
      wstart = scan_pos - (span - 1);
      excess = total - limit;
      if (seed_live && wstart <= seed_last + 1) begin
        seed_last = scan_pos;
        if (excess > peak_excess) begin
          peak_excess = excess;
        end
      end else begin
        if (seed_live) begin
          step_results = {step_results, seed_record(span, 1'b0)};
        end
        seed_live      = 1'b1;
        seed_first     = wstart;
        seed_last      = scan_pos;
        peak_excess    = excess;
        opening_excess = excess;
      end
    end
    if (scan_pos < POSITION_CEILING) begin
      scan_pos++;
    end
    if (fin) begin
      if (seed_live) begin
        step_results = {step_results, seed_record(span, 1'b1)};
      end else begin
        step_results = {step_results, END_ONLY};
      end
      restart_scan();
    end
  endfunction

  function automatic void add_row(input logic [RES_W-1:0] residue, input logic fin,
                                  input bit typed, input scan_result_t want);
    stim_row_t row;
    row.residue = residue;
    row.fin     = fin;
    row.typed   = typed;
    row.want    = want;
    directed_rows = {directed_rows, row};
  endfunction

  // Residue content by flavour: most sequences lean towards strong helix formers so that
  // seeds form, merge and close often; some use any letter, some raw bytes, and the
  // shortest ones fill only windows of three residues or fewer.
  function automatic logic [RES_W-1:0] pick_residue(input int flavour);
    string            rich;
    string            every;
    string            edges;
    logic [RES_W-1:0] c;
    rich  = "AELMQKHEFWAL";
    every = "ACDEFGHIKLMNPQRSTVWY";
    edges = "@[`{AZaz";
    if (flavour == 8) begin
      return RES_W'($urandom);
    end
    if ($urandom_range(9) == 0) begin
      return edges[$urandom_range(edges.len() - 1)];
    end
    if (flavour <= 5 && $urandom_range(3) != 0) begin
      c = rich[$urandom_range(rich.len() - 1)];
    end else begin
      c = every[$urandom_range(every.len() - 1)];
    end
    if ($urandom_range(1) == 1) begin
      c = c | LOWER_CASE_BIT;
    end
    return c;
  endfunction

  // Offers one residue, with the occasional idle cycle in front of it, and once the request
  // is taken records what the scanner should report for it.  The valid line is left high
  // on return so that back-to-back residues are never interrupted within a time step.
  task automatic send_residue(input logic [RES_W-1:0] residue, input logic fin,
                              input bit typed, input scan_result_t want);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.residue      <= residue;
    in_if.last_residue <= fin;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    step_results.delete();
    advance_scan(residue, fin);
    if (typed) begin
      awaited_results = {awaited_results, want};
    end else begin
      awaited_results = {awaited_results, step_results};
    end
    residues_sent++;
    if (fin) begin
      sequences_sent++;
    end
  endtask

  // Waits until every expected result has arrived, then lets the pipeline run dry.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    if (index == REG_WINDOW_LENGTH) begin
      span_reg = data[WIN_LEN_W-1:0];
    end else if (index == REG_HELIX_THRESHOLD) begin
      thr_reg = data;
    end
  endtask

  // New register settings are only applied once the block has gone quiet.
  task automatic configure(input logic [CFG_DATA_W-1:0] span_data,
                           input logic [CFG_DATA_W-1:0] thr_data, input bit touch_spare);
    drain_results();
    write_register(REG_WINDOW_LENGTH, span_data);
    write_register(REG_HELIX_THRESHOLD, thr_data);
    if (touch_spare) begin
      write_register(REG_SPARE_2, CFG_DATA_W'($urandom));
      write_register(REG_SPARE_3, CFG_DATA_W'($urandom));
    end
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Whole sequences, each closed by a last residue, until the budget of residues is spent.
  task automatic random_sequences(input int budget);
    int sent;
    int len;
    int flavour;
    sent = 0;
    while (sent < budget) begin
      flavour = $urandom_range(9);
      if (flavour == 9) begin
        len = $urandom_range(1, 3);
      end else if ($urandom_range(7) == 0) begin
        len = $urandom_range(40, 110);
      end else begin
        len = $urandom_range(4, 36);
      end
      for (int k = 0; k < len; k++) begin
        send_residue(pick_residue(flavour), k == len - 1, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  // The result side stalls at random unless the flow is meant to be steady.
  always @(posedge clk) begin
    out_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Every result taken from the block is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    scan_result_t got;
    scan_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.seed_valid = out_if.seed_valid;
      got.seed_start = out_if.seed_start;
      got.seed_end   = out_if.seed_end;
      got.boost      = out_if.boost_hundredths;
      got.energy     = out_if.energy_half_hundredths;
      got.done       = out_if.sequence_done;
      if (got.seed_valid === 1'b1) begin
        seed_count++;
      end
      if (got.done === 1'b1) begin
        done_count++;
      end
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOWN) begin
          $display("%0t: result with nothing expected", $realtime);
          $display("  actual   seed=%0b start=%0d end=%0d boost=%0d energy=%0d done=%0b",
                   got.seed_valid, got.seed_start, got.seed_end, got.boost,
                   $signed(got.energy), got.done);
        end
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MISMATCH_SHOWN) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected seed=%0b start=%0d end=%0d boost=%0d energy=%0d done=%0b",
                     want.seed_valid, want.seed_start, want.seed_end, want.boost,
                     $signed(want.energy), want.done);
            $display("  actual   seed=%0b start=%0d end=%0d boost=%0d energy=%0d done=%0b",
                     got.seed_valid, got.seed_start, got.seed_end, got.boost,
                     $signed(got.energy), got.done);
          end
        end
      end
    end
  end

  // Ends the run if no request on any channel is taken for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("No progress for %0d cycles, %0d results outstanding", STALL_LIMIT,
             awaited_results.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    string close_and_open;
    rst_n                 = 1'b0;
    steady_flow           = 1'b0;
    in_if.valid           = 1'b0;
    in_if.residue         = '0;
    in_if.last_residue    = 1'b0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_WINDOW_LENGTH;
    cfg_if.data           = '0;
    mismatch_count        = 0;
    seed_count            = 0;
    done_count            = 0;
    residues_sent         = 0;
    sequences_sent        = 0;
    settings_used         = 1;
    span_reg              = 6'd6;
    thr_reg               = 8'd103;
    restart_scan();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sequences at the reset settings (window of six, threshold 103).
    // A single code just below the upper case letters cannot fill a window, so only the
    // end marker comes back.
    add_row("@", 1'b1, 1'b1, END_ONLY);
    // Six of the strongest helix former, the last in lower case: one window of sum 918
    // against a limit of 618 gives an excess of 300, a boost of 350 and an energy of -300.
    for (int k = 0; k < 5; k++) begin
      add_row("E", 1'b0, 1'b0, '0);
    end
    add_row("e", 1'b1, 1'b1, '{1'b1, 16'd0, 16'd5, 10'd350, ENERGY_W'(-300), 1'b1});
    // A seed that fades, a window whose sum equals the limit exactly and so does not
    // qualify, and a fresh seed at the last residue that closes the first one: the closed
    // seed and the final seed both come out for that one residue.
    close_and_open = "EEEEEEGgGgGEEEE";
    for (int k = 0; k < close_and_open.len(); k++) begin
      add_row(close_and_open[k], k == close_and_open.len() - 1, 1'b0, '0);
    end
    // The lowest and highest codes both take the unknown propensity.
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, END_ONLY);

    foreach (directed_rows[r]) begin
      send_residue(directed_rows[r].residue, directed_rows[r].fin, directed_rows[r].typed,
                   directed_rows[r].want);
    end

    // Random sequences over a spread of settings.  The shortest window with no threshold
    // makes every window qualify; the longest with a threshold of 200 makes none.
    configure(8'd1, 8'd0, 1'b0);
    random_sequences(170);
    configure(8'd32, 8'd200, 1'b0);
    random_sequences(150);
    // A window length of zero behaves as one, and one above the maximum as the maximum.
    configure(8'd0, 8'd120, 1'b1);
    random_sequences(170);
    configure(8'd33, 8'd95, 1'b0);
    random_sequences(170);
    // All ones: the window register keeps its low six bits and the threshold sits at 255.
    configure(8'hFF, 8'hFF, 1'b0);
    random_sequences(120);
    // A long stretch in which neither side ever pauses.
    configure(8'd4, 8'd110, 1'b0);
    steady_flow = 1'b1;
    random_sequences(200);
    steady_flow = 1'b0;
    // Upper data bits set on the window register must be dropped.
    configure(8'hC7, 8'd100, 1'b1);
    random_sequences(170);
    for (int k = 0; k < 3; k++) begin
      configure(CFG_DATA_W'($urandom_range(1, 32)), CFG_DATA_W'($urandom_range(90, 130)),
                1'b0);
      random_sequences(70);
    end

    drain_results();

    $display("Streamed %0d residues in %0d sequences across %0d register settings;",
             residues_sent, sequences_sent, settings_used);
    $display("%0d seeds and %0d sequence ends came back.", seed_count, done_count);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/hpw_pkg.sv
rtl/core/hpw_if.sv
rtl/core/hpw_front.sv
rtl/core/hpw_queue.sv
rtl/core/hpw_div.sv
rtl/core/hpw_back.sv
rtl/core/helix_propensity_window_scan_unit.sv
verif/tb_helix_propensity_window_scan_unit.sv
